/* sv/ote_pkg.sv */
// Package for the order table engine: function codes, status codes, widths.
// Used by ote_table and order_table_engine_top. No dependencies.
`default_nettype none
package ote_pkg;
  localparam int unsigned DefaultEntries = 64;

  typedef enum logic [2:0] {
    FUNC_ADD     = 3'd0,
    FUNC_CANCEL  = 3'd1,
    FUNC_EXECUTE = 3'd2,
    FUNC_REPLACE = 3'd3,
    FUNC_DUMP    = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  status;
    logic        entry_valid;
    logic [31:0] order_id;
    logic [7:0]  side;
    logic [31:0] quantity;
    logic [31:0] price;
    logic        last;
  } result_t;
endpackage
`default_nettype wire

/* sv/ote_table.sv */
// Order table engine core: slot memory, insertion-ordered chain walk, sequencer.
// Depends on ote_pkg.
`default_nettype none
module ote_table
  import ote_pkg::*;
#(
  parameter int unsigned Entries = DefaultEntries
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [2:0]  func_i,
  input  wire logic [31:0] order_id_i,
  input  wire logic [7:0]  side_i,
  input  wire logic [30:0] quantity_i,
  input  wire logic [31:0] price_i,
  output logic             busy_o,
  output logic             res_valid_o,
  output result_t          res_o,
  input  wire logic        res_stall_i
);
  localparam int unsigned SW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned CW = $clog2(Entries + 1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_ALLOC = 7'b0000010,
    ST_RD    = 7'b0000100,
    ST_CMP   = 7'b0001000,
    ST_OUT   = 7'b0010000,
    ST_LINK  = 7'b0100000,
    ST_DUMP  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [31:0]   mem_id   [Entries];
  logic [7:0]    mem_side [Entries];
  logic [31:0]   mem_qty  [Entries];
  logic [31:0]   mem_price[Entries];
  logic [SW-1:0] mem_next [Entries];
  logic [Entries-1:0] valid_q;

  logic [SW-1:0] first_q, final_q;
  logic [CW-1:0] count_q, n_q;
  logic [SW-1:0] cur_q, prv_q, alloc_q;
  logic          hp_q;
  logic [2:0]    func_q;
  logic [31:0]   id_q, price_q;
  logic [7:0]    side_q;
  logic [30:0]   qty_q;
  logic [SW-1:0] rd_addr;
  logic          rd_en;
  logic [31:0]   rd_id, rd_qty, rd_price;
  logic [7:0]    rd_side;
  logic [SW-1:0] rd_next;
  logic          out_full_q;
  result_t       out_q;

  // memory write port
  logic          wr_en, wr_link, wr_data;
  logic [SW-1:0] wr_addr, link_addr, link_val;
  logic [31:0]   wr_id, wr_qty, wr_price;
  logic [7:0]    wr_side;
  logic [SW-1:0] wr_next;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_id    <= mem_id[rd_addr];
      rd_side  <= mem_side[rd_addr];
      rd_qty   <= mem_qty[rd_addr];
      rd_price <= mem_price[rd_addr];
      rd_next  <= mem_next[rd_addr];
    end
    if (wr_en) begin
      if (wr_data) begin
        mem_id[wr_addr]    <= wr_id;
        mem_side[wr_addr]  <= wr_side;
        mem_qty[wr_addr]   <= wr_qty;
        mem_price[wr_addr] <= wr_price;
      end
      mem_next[wr_addr] <= wr_next;
    end
    if (wr_link) mem_next[link_addr] <= link_val;
  end

  logic          free_found;
  logic [SW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  logic        out_free;
  logic [31:0] sub_qty;
  assign out_free = !out_full_q || !res_stall_i;
  assign sub_qty  = rd_qty - {1'b0, qty_q};
  assign busy_o   = (state_q != ST_IDLE);

  result_t res_d;
  logic    emit;
  logic    remove;
  logic [SW-1:0] first_d, final_d;
  logic [CW-1:0] count_d;
  logic [Entries-1:0] valid_d;

  always_comb begin
    state_d = state_q;
    rd_en = 1'b0;
    rd_addr = cur_q;
    wr_en = 1'b0; wr_data = 1'b0; wr_link = 1'b0;
    wr_addr = cur_q; link_addr = prv_q; link_val = rd_next;
    wr_id = id_q; wr_side = side_q; wr_qty = rd_qty; wr_price = rd_price;
    wr_next = rd_next;
    emit = 1'b0;
    res_d = '0;
    res_d.last = 1'b1;
    remove = 1'b0;
    first_d = first_q; final_d = final_q; count_d = count_q; valid_d = valid_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (func_i == FUNC_ADD) state_d = ST_ALLOC;
          else if (func_i inside {FUNC_CANCEL, FUNC_EXECUTE, FUNC_REPLACE,
                                  FUNC_DUMP}) begin
            state_d = (count_q == '0) ? ST_OUT : ST_RD;
          end else state_d = ST_OUT;
        end
      end
      ST_ALLOC: begin
        if (out_free) begin
          emit = 1'b1;
          state_d = ST_IDLE;
          if (count_q >= CW'(Entries) || !free_found) begin
            res_d.status = STATUS_FULL;
          end else begin
            wr_en = 1'b1; wr_data = 1'b1; wr_addr = free_idx;
            wr_qty = {1'b0, qty_q}; wr_price = price_q; wr_next = '0;
            if (count_q != '0) begin
              wr_link = 1'b1; link_addr = final_q; link_val = free_idx;
            end else first_d = free_idx;
            final_d = free_idx;
            valid_d[free_idx] = 1'b1;
            count_d = count_q + 1'b1;
            res_d.entry_valid = 1'b1;
            res_d.order_id = id_q; res_d.side = side_q;
            res_d.quantity = {1'b0, qty_q}; res_d.price = price_q;
          end
        end
      end
      ST_RD: begin
        rd_en = 1'b1;
        state_d = (func_q == FUNC_DUMP) ? ST_DUMP : ST_CMP;
      end
      ST_CMP: begin
        if (rd_id == id_q) state_d = ST_LINK;
        else if (n_q + 1'b1 >= count_q) state_d = ST_OUT;
        else begin
          rd_en = 1'b1; rd_addr = rd_next; state_d = ST_CMP;
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          emit = 1'b1;
          res_d.entry_valid = 1'b1;
          res_d.order_id = rd_id; res_d.side = rd_side;
          res_d.quantity = rd_qty; res_d.price = rd_price;
          res_d.last = (n_q + 1'b1 == count_q);
          if (res_d.last) state_d = ST_IDLE;
          else begin
            rd_en = 1'b1; rd_addr = rd_next;
          end
        end
      end
      ST_LINK: begin
        if (out_free) begin
          emit = 1'b1;
          state_d = ST_IDLE;
          res_d.order_id = rd_id; res_d.side = rd_side;
          res_d.quantity = rd_qty; res_d.price = rd_price;
          res_d.entry_valid = 1'b1;
          if (func_q == FUNC_CANCEL) begin
            remove = 1'b1; res_d.entry_valid = 1'b0;
          end else if (func_q == FUNC_EXECUTE) begin
            res_d.quantity = sub_qty;
            wr_en = 1'b1; wr_data = 1'b1; wr_id = rd_id; wr_side = rd_side;
            wr_qty = sub_qty;
            if (sub_qty == '0) begin
              remove = 1'b1; res_d.entry_valid = 1'b0;
            end
          end else begin
            res_d.quantity = {1'b0, qty_q}; res_d.price = price_q;
            wr_en = 1'b1; wr_data = 1'b1; wr_id = rd_id; wr_side = rd_side;
            wr_qty = {1'b0, qty_q}; wr_price = price_q;
          end
          if (remove) begin
            if (hp_q) begin
              wr_link = 1'b1; link_addr = prv_q; link_val = rd_next;
            end else first_d = rd_next;
            if (final_q == cur_q) final_d = hp_q ? prv_q : '0;
            valid_d[cur_q] = 1'b0;
            count_d = count_q - 1'b1;
            if (count_d == '0) begin
              first_d = '0; final_d = '0;
            end
          end
        end
      end
      ST_OUT: begin
        if (out_free) begin
          emit = 1'b1;
          state_d = ST_IDLE;
          if (func_q inside {FUNC_CANCEL, FUNC_EXECUTE, FUNC_REPLACE})
            res_d.status = STATUS_NOT_FOUND;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= '0;
      first_q <= '0; final_q <= '0; count_q <= '0;
      out_full_q <= 1'b0;
      n_q <= '0; cur_q <= '0; prv_q <= '0; hp_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      first_q <= first_d; final_q <= final_d; count_q <= count_d;
      if (emit) out_full_q <= 1'b1;
      else if (!res_stall_i) out_full_q <= 1'b0;
      if (state_q == ST_IDLE) begin
        n_q <= '0; cur_q <= first_q; prv_q <= '0; hp_q <= 1'b0;
      end else if ((state_q == ST_CMP && state_d == ST_CMP) ||
                   (state_q == ST_DUMP && rd_en)) begin
        n_q <= n_q + 1'b1; prv_q <= cur_q; hp_q <= 1'b1; cur_q <= rd_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && state_q == ST_IDLE) begin
      func_q <= func_i; id_q <= order_id_i; side_q <= side_i;
      qty_q <= quantity_i; price_q <= price_i;
    end
    if (emit) out_q <= res_d;
  end

  assign res_valid_o = out_full_q;
  assign res_o       = out_q;
endmodule
`default_nettype wire

/* sv/order_table_engine_top.sv */
// Order table engine top level: ports and the table core.
// Depends on ote_pkg and ote_table.
//
// Usage: present an operation on the input channel (in_valid_i, in_stall_o).
// Add, cancel, execute and replace give one result; dump gives one result per
// live order, oldest first, with last_o on the final one (one result when the
// table is empty). Results leave on the output channel (out_valid_o,
// out_stall_i) through an output register.
// An add takes a free slot and writes its result to the result register; a
// lookup walks the chain in insertion order until the id matches or the last
// live order is read; a dump walks the chain in the same order and emits each
// order as it is read; an empty dump or an unused code goes straight to the
// output. The chain walk reads one slot per cycle from the slot memory; in a
// dump a stalled receiver holds it. One item is in work at a time; in_stall_o
// is high while it is. A stalled receiver holds the result register and the
// sequencer waits. Reset empties the table at once; no clearing pass is needed.
`default_nettype none
module order_table_engine_top
  import ote_pkg::*;
#(
  parameter int unsigned ENTRIES = DefaultEntries
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  func_i,
  input  wire logic [31:0] order_id_i,
  input  wire logic [7:0]  side_i,
  input  wire logic [30:0] quantity_i,
  input  wire logic [31:0] price_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic             entry_valid_o,
  output logic [31:0]      order_id_out_o,
  output logic [7:0]       side_out_o,
  output logic [31:0]      quantity_out_o,
  output logic [31:0]      price_out_o,
  output logic             last_o
);
  logic    busy;
  result_t res;

  ote_table #(.Entries(ENTRIES)) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i && !busy),
    .func_i      (func_i),
    .order_id_i  (order_id_i),
    .side_i      (side_i),
    .quantity_i  (quantity_i),
    .price_i     (price_i),
    .busy_o      (busy),
    .res_valid_o (out_valid_o),
    .res_o       (res),
    .res_stall_i (out_stall_i)
  );

  assign in_stall_o     = busy;
  assign status_o       = res.status;
  assign entry_valid_o  = res.entry_valid;
  assign order_id_out_o = res.order_id;
  assign side_out_o     = res.side;
  assign quantity_out_o = res.quantity;
  assign price_out_o    = res.price;
  assign last_o         = res.last;
endmodule
`default_nettype wire
